// ===== hdl/bscu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared constants and types for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bscu_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_COEF  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_NINE = 2'd3;

    // pipeline shape
    localparam int FRONT_STAGES = 13;
    localparam int BACK_STAGES  = 7;

    // divider: 64-bit dividend magnitude, 31-bit divisor magnitude
    localparam int QUOT_W = 64;
    localparam int DEN_W  = 31;

    // arithmetic constants
    localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
    localparam logic signed [26:0] TEMP_ROUND    = 27'sd128;
    localparam logic signed [15:0] TEMP_MIN      = 16'sh8000;
    localparam logic signed [15:0] TEMP_MAX      = 16'sh7FFF;
    localparam logic [63:0]        DIV_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic [20:0]        PRESS_BASE    = 21'h10_0000;
    localparam logic [11:0]        NUM_SCALE     = 12'd3125;
    localparam logic [24:0]        PRESS_MAX     = 25'h1FF_FFFF;

    // per-item data that rides alongside the divider
    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic               divide_fault;
    } bscu_side_t;

endpackage
`default_nettype wire

// ===== hdl/bscu_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bscu_divider
// Pipelined restoring divider, one quotient bit per stage, with per-stage
// valid bits and a stall that only holds stages with no hole behind them.
// ----------------------------------------------------------------------------
module bscu_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bscu_pkg::QUOT_W-1:0] in_num,
    input  wire logic [bscu_pkg::DEN_W-1:0]  in_den,
    input  wire logic                        in_neg,
    input  wire bscu_pkg::bscu_side_t        in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bscu_pkg::QUOT_W-1:0]      out_quot,
    output logic                             out_neg,
    output bscu_pkg::bscu_side_t             out_side
);

    localparam int QW    = bscu_pkg::QUOT_W;
    localparam int DW    = bscu_pkg::DEN_W;
    localparam int STEPS = bscu_pkg::QUOT_W;

    logic [STEPS-1:0]     v_reg;
    logic [STEPS-1:0]     en;
    logic [QW-1:0]        q_reg   [STEPS];
    logic [DW-1:0]        rem_reg [STEPS];
    logic [DW-1:0]        den_reg [STEPS];
    logic [STEPS-1:0]     neg_reg;
    bscu_pkg::bscu_side_t side_reg [STEPS];

    genvar k;
    for (k = 0; k < STEPS; k++) begin : g_step
        logic [QW-1:0]        q_in;
        logic [DW-1:0]        rem_in;
        logic [DW-1:0]        den_in;
        logic                 neg_in;
        logic                 v_in;
        bscu_pkg::bscu_side_t side_in;
        logic [DW:0]          trial;
        logic [DW:0]          diff;
        logic                 ge;

        if (k == 0) begin : g_head
            assign q_in    = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign neg_in  = in_neg;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_body
            assign q_in    = q_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // a stage moves when it or any later stage is empty or the output drains
        assign en[k] = out_ready | ~(&v_reg[STEPS-1:k]);

        // shift next dividend bit into the partial remainder
        assign trial = {rem_in, q_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                q_reg[k]    <= {q_in[QW-2:0], ge};
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                den_reg[k]  <= den_in;
                neg_reg[k]  <= neg_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STEPS-1];
    assign out_quot  = q_reg[STEPS-1];
    assign out_neg   = neg_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/barometric_sensor_compensation_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_unit
// Second-order temperature and pressure compensation of raw 20-bit sensor
// conversions, fully pipelined in fixed point.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_ready is high: a raw temperature and raw
// pressure conversion. Returns one item per input, in order: temperature in
// 0.01 degC (signed, saturated), pressure in Pa as unsigned Q17.8
// (saturated), and a flag set when the calibration divisor is zero (pressure
// is then 0). The path is 13 polynomial stages, a 64-stage bit-per-stage
// divider and 7 stages of pressure correction plus the output register.
// Throughput is one item per cycle; the pipeline keeps accepting while a
// result waits on m_ready as long as any stage holds a bubble. Calibration
// is loaded through cfg_wr_en/cfg_index/cfg_wr_data: index 0 temperature
// coefficients T1..T3, 1 pressure P1..P4, 2 pressure P5..P8, 3 pressure P9.
// Write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [19:0]                         s_raw_temperature,
    input  wire logic [19:0]                         s_raw_pressure,
    // result items
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [15:0]                       m_temperature_centi,
    output logic [24:0]                              m_pressure_q8,
    output logic                                     m_divide_fault,
    // calibration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [bscu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bscu_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int NF = bscu_pkg::FRONT_STAGES;
    localparam int NB = bscu_pkg::BACK_STAGES;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_coef_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coef_reg  <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bscu_pkg::CFG_TEMP_COEF:  temp_coef_reg  <= cfg_wr_data[47:0];
                bscu_pkg::CFG_PRESS_LOW:  press_low_reg  <= cfg_wr_data;
                bscu_pkg::CFG_PRESS_HIGH: press_high_reg <= cfg_wr_data;
                bscu_pkg::CFG_PRESS_NINE: press_nine_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    logic        [15:0] c_t1, c_p1;
    logic signed [15:0] c_t2, c_t3;
    logic signed [15:0] c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;

    assign c_t1 = temp_coef_reg[15:0];
    assign c_t2 = $signed(temp_coef_reg[31:16]);
    assign c_t3 = $signed(temp_coef_reg[47:32]);
    assign c_p1 = press_low_reg[15:0];
    assign c_p2 = $signed(press_low_reg[31:16]);
    assign c_p3 = $signed(press_low_reg[47:32]);
    assign c_p4 = $signed(press_low_reg[63:48]);
    assign c_p5 = $signed(press_high_reg[15:0]);
    assign c_p6 = $signed(press_high_reg[31:16]);
    assign c_p7 = $signed(press_high_reg[47:32]);
    assign c_p8 = $signed(press_high_reg[63:48]);
    assign c_p9 = $signed(press_nine_reg);

    // ------------------------------------------------------------------
    // flow control: a stage loads when it or some later stage is empty or the
    // stage after the group is taking data
    // ------------------------------------------------------------------
    logic [NF-1:0] f_v_reg, f_en;
    logic [NB-1:0] b_v_reg, b_en;
    logic          m_valid_reg;
    logic          out_en;
    logic          div_in_ready, div_out_valid;

    assign out_en = !m_valid_reg || m_ready;

    genvar g;
    for (g = 0; g < NF; g++) begin : g_fen
        assign f_en[g] = div_in_ready | ~(&f_v_reg[NF-1:g]);
    end
    for (g = 0; g < NB; g++) begin : g_ben
        assign b_en[g] = out_en | ~(&b_v_reg[NB-1:g]);
    end

    assign s_ready = f_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg     <= '0;
            b_v_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (f_en[0]) begin
                f_v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (f_en[k]) begin
                    f_v_reg[k] <= f_v_reg[k-1];
                end
            end
            if (b_en[0]) begin
                b_v_reg[0] <= div_out_valid;
            end
            for (int k = 1; k < NB; k++) begin
                if (b_en[k]) begin
                    b_v_reg[k] <= b_v_reg[k-1];
                end
            end
            if (out_en) begin
                m_valid_reg <= b_v_reg[NB-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // front: temperature polynomial, then pressure divisor and dividend
    // ------------------------------------------------------------------
    // S1: differences against T1
    logic signed [17:0] st1_ta_next, st1_ta_reg;
    logic signed [16:0] st1_tb_next, st1_tb_reg;
    logic [19:0]        st1_adcp_reg;
    // S2: products
    logic signed [33:0] st2_tm1_next, st2_tm1_reg;
    logic signed [33:0] st2_tbb_next;
    logic [31:0]        st2_tbb_reg;
    logic [19:0]        st2_adcp_reg;
    // S3
    logic signed [22:0] st3_v1_reg;
    logic signed [36:0] st3_tm2_next, st3_tm2_reg;
    logic [19:0]        st3_adcp_reg;
    // S4: t_fine
    logic signed [23:0] st4_tfine_next, st4_tfine_reg;
    logic [19:0]        st4_adcp_reg;
    // S5: temperature out, pressure offset
    logic signed [26:0] st5_t5_next;
    logic signed [18:0] st5_traw;
    logic signed [15:0] st5_tc_next, st5_tc_reg;
    logic signed [24:0] st5_pv1_next, st5_pv1_reg;
    logic [19:0]        st5_adcp_reg;
    // S6
    logic signed [49:0] st6_vv_next;
    logic [47:0]        st6_vv_reg;
    logic signed [40:0] st6_vp5_next, st6_vp5_reg;
    logic signed [40:0] st6_vp2_next, st6_vp2_reg;
    logic signed [15:0] st6_tc_reg;
    logic [19:0]        st6_adcp_reg;
    // S7: split products against P6 and P3
    logic signed [48:0] st7_lo6_next, st7_lo6_reg, st7_lo3_next, st7_lo3_reg;
    logic signed [32:0] st7_hi6_next, st7_hi3_next;
    logic [31:0]        st7_hi6_reg, st7_hi3_reg;
    logic signed [40:0] st7_vp5_reg, st7_vp2_reg;
    logic signed [15:0] st7_tc_reg;
    logic [19:0]        st7_adcp_reg;
    // S8
    logic [63:0]        st8_x6_next, st8_x6_reg, st8_x3_next, st8_x3_reg;
    logic signed [40:0] st8_vp5_reg, st8_vp2_reg;
    logic signed [15:0] st8_tc_reg;
    logic [19:0]        st8_adcp_reg;
    // S9
    logic [63:0]        st9_v2_next, st9_v2_reg, st9_w_next, st9_w_reg;
    logic signed [15:0] st9_tc_reg;
    logic [19:0]        st9_adcp_reg;
    // S10
    logic [47:0]        st10_ulo_next, st10_ulo_reg, st10_uhi_next;
    logic [31:0]        st10_uhi_reg;
    logic [20:0]        st10_pp;
    logic [63:0]        st10_nn_next, st10_nn_reg;
    logic signed [15:0] st10_tc_reg;
    // S11
    logic [63:0]        st11_u;
    logic [43:0]        st11_nlo_next, st11_nlo_reg;
    logic [43:0]        st11_nhi_next;
    logic [31:0]        st11_nhi_reg;
    logic [30:0]        st11_d_reg;
    logic signed [15:0] st11_tc_reg;
    // S12
    logic [63:0]        st12_num_reg;
    logic [30:0]        st12_d_reg;
    logic signed [15:0] st12_tc_reg;
    logic               st12_fault_reg;
    // S13: magnitudes for the divider
    logic [63:0]          st13_un_reg;
    logic [30:0]          st13_ud_reg;
    logic                 st13_neg_reg;
    bscu_pkg::bscu_side_t st13_side_reg;

    assign st1_ta_next = $signed({1'b0, s_raw_temperature[19:3]})
                       - $signed({1'b0, c_t1, 1'b0});
    assign st1_tb_next = $signed({1'b0, s_raw_temperature[19:4]})
                       - $signed({1'b0, c_t1});

    assign st2_tm1_next = st1_ta_reg * c_t2;
    assign st2_tbb_next = st1_tb_reg * st1_tb_reg;

    assign st3_tm2_next = $signed({1'b0, st2_tbb_reg[31:12]}) * c_t3;

    assign st4_tfine_next = {st3_v1_reg[22], st3_v1_reg}
                          + {st3_tm2_reg[36], st3_tm2_reg[36:14]};

    // temperature = (t_fine * 5 + 128) >>> 8, saturated
    always_comb begin
        st5_t5_next = ({{3{st4_tfine_reg[23]}}, st4_tfine_reg} <<< 2)
                    + {{3{st4_tfine_reg[23]}}, st4_tfine_reg}
                    + bscu_pkg::TEMP_ROUND;
        st5_traw = $signed(st5_t5_next[26:8]);
        if (st5_traw < -19'sd32768) begin
            st5_tc_next = bscu_pkg::TEMP_MIN;
        end else if (st5_traw > 19'sd32767) begin
            st5_tc_next = bscu_pkg::TEMP_MAX;
        end else begin
            st5_tc_next = st5_traw[15:0];
        end
    end
    assign st5_pv1_next = {st4_tfine_reg[23], st4_tfine_reg} - bscu_pkg::T_FINE_OFFSET;

    assign st6_vv_next  = st5_pv1_reg * st5_pv1_reg;
    assign st6_vp5_next = st5_pv1_reg * c_p5;
    assign st6_vp2_next = st5_pv1_reg * c_p2;

    // vv * P6 and vv * P3 in a low 32-bit and a high 16-bit part, low 64 bits kept
    assign st7_lo6_next = $signed({1'b0, st6_vv_reg[31:0]}) * c_p6;
    assign st7_hi6_next = $signed({1'b0, st6_vv_reg[47:32]}) * c_p6;
    assign st7_lo3_next = $signed({1'b0, st6_vv_reg[31:0]}) * c_p3;
    assign st7_hi3_next = $signed({1'b0, st6_vv_reg[47:32]}) * c_p3;

    assign st8_x6_next = {{15{st7_lo6_reg[48]}}, st7_lo6_reg} + {st7_hi6_reg, 32'b0};
    assign st8_x3_next = {{15{st7_lo3_reg[48]}}, st7_lo3_reg} + {st7_hi3_reg, 32'b0};

    assign st9_v2_next = st8_x6_reg
                       + ({{23{st8_vp5_reg[40]}}, st8_vp5_reg} << 17)
                       + ({{48{c_p4[15]}}, c_p4} << 35);
    assign st9_w_next  = {{8{st8_x3_reg[63]}}, st8_x3_reg[63:8]}
                       + ({{23{st8_vp2_reg[40]}}, st8_vp2_reg} << 12)
                       + bscu_pkg::DIV_BIAS;

    // divisor product (w * P1) in halves; dividend (base - raw) << 31 - v2
    assign st10_ulo_next = st9_w_reg[31:0] * c_p1;
    assign st10_uhi_next = st9_w_reg[63:32] * c_p1;
    assign st10_pp       = bscu_pkg::PRESS_BASE - {1'b0, st9_adcp_reg};
    assign st10_nn_next  = {12'b0, st10_pp, 31'b0} - st9_v2_reg;

    assign st11_u        = {16'b0, st10_ulo_reg} + {st10_uhi_reg, 32'b0};
    assign st11_nlo_next = st10_nn_reg[31:0] * bscu_pkg::NUM_SCALE;
    assign st11_nhi_next = st10_nn_reg[63:32] * bscu_pkg::NUM_SCALE;

    always_ff @(posedge aclk) begin
        if (f_en[0]) begin
            st1_ta_reg   <= st1_ta_next;
            st1_tb_reg   <= st1_tb_next;
            st1_adcp_reg <= s_raw_pressure;
        end
        if (f_en[1]) begin
            st2_tm1_reg  <= st2_tm1_next;
            st2_tbb_reg  <= st2_tbb_next[31:0];
            st2_adcp_reg <= st1_adcp_reg;
        end
        if (f_en[2]) begin
            st3_v1_reg   <= st2_tm1_reg[33:11];
            st3_tm2_reg  <= st3_tm2_next;
            st3_adcp_reg <= st2_adcp_reg;
        end
        if (f_en[3]) begin
            st4_tfine_reg <= st4_tfine_next;
            st4_adcp_reg  <= st3_adcp_reg;
        end
        if (f_en[4]) begin
            st5_tc_reg   <= st5_tc_next;
            st5_pv1_reg  <= st5_pv1_next;
            st5_adcp_reg <= st4_adcp_reg;
        end
        if (f_en[5]) begin
            st6_vv_reg   <= st6_vv_next[47:0];
            st6_vp5_reg  <= st6_vp5_next;
            st6_vp2_reg  <= st6_vp2_next;
            st6_tc_reg   <= st5_tc_reg;
            st6_adcp_reg <= st5_adcp_reg;
        end
        if (f_en[6]) begin
            st7_lo6_reg  <= st7_lo6_next;
            st7_hi6_reg  <= st7_hi6_next[31:0];
            st7_lo3_reg  <= st7_lo3_next;
            st7_hi3_reg  <= st7_hi3_next[31:0];
            st7_vp5_reg  <= st6_vp5_reg;
            st7_vp2_reg  <= st6_vp2_reg;
            st7_tc_reg   <= st6_tc_reg;
            st7_adcp_reg <= st6_adcp_reg;
        end
        if (f_en[7]) begin
            st8_x6_reg   <= st8_x6_next;
            st8_x3_reg   <= st8_x3_next;
            st8_vp5_reg  <= st7_vp5_reg;
            st8_vp2_reg  <= st7_vp2_reg;
            st8_tc_reg   <= st7_tc_reg;
            st8_adcp_reg <= st7_adcp_reg;
        end
        if (f_en[8]) begin
            st9_v2_reg   <= st9_v2_next;
            st9_w_reg    <= st9_w_next;
            st9_tc_reg   <= st8_tc_reg;
            st9_adcp_reg <= st8_adcp_reg;
        end
        if (f_en[9]) begin
            st10_ulo_reg <= st10_ulo_next;
            st10_uhi_reg <= st10_uhi_next[31:0];
            st10_nn_reg  <= st10_nn_next;
            st10_tc_reg  <= st9_tc_reg;
        end
        if (f_en[10]) begin
            st11_d_reg   <= st11_u[63:33];
            st11_nlo_reg <= st11_nlo_next;
            st11_nhi_reg <= st11_nhi_next[31:0];
            st11_tc_reg  <= st10_tc_reg;
        end
        if (f_en[11]) begin
            st12_num_reg   <= {20'b0, st11_nlo_reg} + {st11_nhi_reg, 32'b0};
            st12_d_reg     <= st11_d_reg;
            st12_fault_reg <= (st11_d_reg == '0);
            st12_tc_reg    <= st11_tc_reg;
        end
        if (f_en[12]) begin
            st13_un_reg  <= st12_num_reg[63] ? (64'd0 - st12_num_reg) : st12_num_reg;
            st13_ud_reg  <= st12_d_reg[30] ? (31'd0 - st12_d_reg) : st12_d_reg;
            st13_neg_reg <= st12_num_reg[63] ^ st12_d_reg[30];
            st13_side_reg.temperature_centi <= st12_tc_reg;
            st13_side_reg.divide_fault      <= st12_fault_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider: magnitude quotient, sign applied afterwards
    // ------------------------------------------------------------------
    logic [63:0]          div_quot;
    logic                 div_neg;
    bscu_pkg::bscu_side_t div_side;

    bscu_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_v_reg[NF-1]),
        .in_ready  (div_in_ready),
        .in_num    (st13_un_reg),
        .in_den    (st13_ud_reg),
        .in_neg    (st13_neg_reg),
        .in_side   (st13_side_reg),
        .out_valid (div_out_valid),
        .out_ready (b_en[0]),
        .out_quot  (div_quot),
        .out_neg   (div_neg),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // back: P9 / P8 corrections and P7 offset, all modulo 2^64
    // ------------------------------------------------------------------
    logic [63:0]          bk1_q_reg;
    bscu_pkg::bscu_side_t bk1_side_reg;

    logic [63:0]          bk2_x;
    logic signed [48:0]   bk2_m1lo_next, bk2_m1lo_reg, bk2_b8lo_next, bk2_b8lo_reg;
    logic signed [47:0]   bk2_m1hi_next, bk2_b8hi_next;
    logic [31:0]          bk2_m1hi_reg, bk2_b8hi_reg;
    logic [63:0]          bk2_x_reg, bk2_q_reg;
    bscu_pkg::bscu_side_t bk2_side_reg;

    logic [63:0]          bk3_m1_reg, bk3_bp_reg, bk3_x_reg, bk3_q_reg;
    bscu_pkg::bscu_side_t bk3_side_reg;

    logic [63:0]          bk4_ll_next, bk4_ll_reg, bk4_c1_next, bk4_c2_next;
    logic [31:0]          bk4_c1_reg, bk4_c2_reg;
    logic [63:0]          bk4_bb_reg, bk4_q_reg;
    bscu_pkg::bscu_side_t bk4_side_reg;

    logic [31:0]          bk5_cs;
    logic [63:0]          bk5_m2_reg, bk5_bb_reg, bk5_q_reg;
    bscu_pkg::bscu_side_t bk5_side_reg;

    logic [63:0]          bk6_s_reg;
    bscu_pkg::bscu_side_t bk6_side_reg;

    logic [63:0]          bk7_r_reg;
    bscu_pkg::bscu_side_t bk7_side_reg;

    logic [24:0]          out_press_next;
    logic signed [15:0]   out_temp_reg;
    logic [24:0]          out_press_reg;
    logic                 out_fault_reg;

    // x = p >>> 13
    assign bk2_x         = {{13{bk1_q_reg[63]}}, bk1_q_reg[63:13]};
    assign bk2_m1lo_next = $signed({1'b0, bk2_x[31:0]}) * c_p9;
    assign bk2_m1hi_next = $signed(bk2_x[63:32]) * c_p9;
    assign bk2_b8lo_next = $signed({1'b0, bk1_q_reg[31:0]}) * c_p8;
    assign bk2_b8hi_next = $signed(bk1_q_reg[63:32]) * c_p8;

    // (P9 * x) * x: cross terms only matter in their low half
    assign bk4_ll_next = bk3_m1_reg[31:0] * bk3_x_reg[31:0];
    assign bk4_c1_next = bk3_m1_reg[63:32] * bk3_x_reg[31:0];
    assign bk4_c2_next = bk3_m1_reg[31:0] * bk3_x_reg[63:32];

    assign bk5_cs = bk4_c1_reg + bk4_c2_reg;

    // a divide fault or a negative result gives 0, too large clamps to full scale
    always_comb begin
        if (bk7_side_reg.divide_fault || bk7_r_reg[63]) begin
            out_press_next = '0;
        end else if (|bk7_r_reg[62:25]) begin
            out_press_next = bscu_pkg::PRESS_MAX;
        end else begin
            out_press_next = bk7_r_reg[24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en[0]) begin
            bk1_q_reg    <= div_neg ? (64'd0 - div_quot) : div_quot;
            bk1_side_reg <= div_side;
        end
        if (b_en[1]) begin
            bk2_m1lo_reg <= bk2_m1lo_next;
            bk2_m1hi_reg <= bk2_m1hi_next[31:0];
            bk2_b8lo_reg <= bk2_b8lo_next;
            bk2_b8hi_reg <= bk2_b8hi_next[31:0];
            bk2_x_reg    <= bk2_x;
            bk2_q_reg    <= bk1_q_reg;
            bk2_side_reg <= bk1_side_reg;
        end
        if (b_en[2]) begin
            bk3_m1_reg   <= {{15{bk2_m1lo_reg[48]}}, bk2_m1lo_reg} + {bk2_m1hi_reg, 32'b0};
            bk3_bp_reg   <= {{15{bk2_b8lo_reg[48]}}, bk2_b8lo_reg} + {bk2_b8hi_reg, 32'b0};
            bk3_x_reg    <= bk2_x_reg;
            bk3_q_reg    <= bk2_q_reg;
            bk3_side_reg <= bk2_side_reg;
        end
        if (b_en[3]) begin
            bk4_ll_reg   <= bk4_ll_next;
            bk4_c1_reg   <= bk4_c1_next[31:0];
            bk4_c2_reg   <= bk4_c2_next[31:0];
            bk4_bb_reg   <= {{19{bk3_bp_reg[63]}}, bk3_bp_reg[63:19]};
            bk4_q_reg    <= bk3_q_reg;
            bk4_side_reg <= bk3_side_reg;
        end
        if (b_en[4]) begin
            bk5_m2_reg   <= bk4_ll_reg + {bk5_cs, 32'b0};
            bk5_bb_reg   <= bk4_bb_reg;
            bk5_q_reg    <= bk4_q_reg;
            bk5_side_reg <= bk4_side_reg;
        end
        if (b_en[5]) begin
            bk6_s_reg    <= bk5_q_reg + {{25{bk5_m2_reg[63]}}, bk5_m2_reg[63:25]}
                          + bk5_bb_reg;
            bk6_side_reg <= bk5_side_reg;
        end
        if (b_en[6]) begin
            bk7_r_reg    <= {{8{bk6_s_reg[63]}}, bk6_s_reg[63:8]}
                          + {{44{c_p7[15]}}, c_p7, 4'b0};
            bk7_side_reg <= bk6_side_reg;
        end
        if (out_en) begin
            out_temp_reg  <= bk7_side_reg.temperature_centi;
            out_press_reg <= out_press_next;
            out_fault_reg <= bk7_side_reg.divide_fault;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_pressure_q8       = out_press_reg;
    assign m_divide_fault      = out_fault_reg;

endmodule
`default_nettype wire

// ===== bench/tb_barometric_sensor_compensation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation_unit
// Self-checking bench: random-paced raw conversions in, compensated
// temperature/pressure items checked in order against a fixed-point predictor.
// ----------------------------------------------------------------------------
// Runs several calibration sets (reset zeros, typical, all ones, signed
// extremes, zero P1 for the divisor fault, random, near typical); most start
// with directed field extremes (a longer sweep for the typical set), then
// random items. Calibration is only rewritten once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation_unit;

    localparam int  CLK_HALF   = 6;
    localparam int  DRAIN_WAIT = 100;
    localparam longint CYCLE_LIMIT = 400000;

    // calibration sets
    localparam int SET_TYPICAL  = 0;
    localparam int SET_ONES     = 1;
    localparam int SET_EXT_POS  = 2;
    localparam int SET_EXT_NEG  = 3;
    localparam int SET_NO_P1    = 4;
    localparam int SET_RANDOM   = 5;
    localparam int SET_NEAR_TYP = 6;

    typedef struct packed {
        bit signed [15:0] temperature_centi;
        bit [24:0]        pressure_q8;
        bit               divide_fault;
    } reading_t;

    // ------------------------------------------------------------------
    // Scoreboard: holds the calibration copy and the expected readings
    // ------------------------------------------------------------------
    class compensation_scoreboard;
        bit [47:0] temp_coef;
        bit [63:0] press_low;
        bit [63:0] press_high;
        bit [15:0] press_nine;
        reading_t  pending_readings[$];
        int        errors;

        function new();
            temp_coef = '0; press_low = '0; press_high = '0; press_nine = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [bscu_pkg::CFG_INDEX_W-1:0] idx, bit [63:0] data);
            case (idx)
                bscu_pkg::CFG_TEMP_COEF:  temp_coef  = data[47:0];
                bscu_pkg::CFG_PRESS_LOW:  press_low  = data;
                bscu_pkg::CFG_PRESS_HIGH: press_high = data;
                bscu_pkg::CFG_PRESS_NINE: press_nine = data[15:0];
                default: ;
            endcase
        endfunction

        static function bit [63:0] sext16(bit [15:0] v);
            return {{48{v[15]}}, v};
        endfunction

        static function bit [63:0] shr_signed(bit [63:0] x, int s);
            bit signed [63:0] sx;
            sx = x;
            return sx >>> s;
        endfunction

        // signed 64-bit divide, truncating toward zero
        static function bit [63:0] div_trunc(bit [63:0] n, bit [63:0] d);
            bit [63:0] un, ud, q;
            un = n[63] ? -n : n;
            ud = d[63] ? -d : d;
            q  = un / ud;
            return (n[63] ^ d[63]) ? -q : q;
        endfunction

        function reading_t compensate(bit [19:0] raw_t, bit [19:0] raw_p);
            bit [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            bit [63:0] a, b, v1, v2, fine, pr, at, ap;
            bit signed [63:0] centi;
            reading_t r;
            at = raw_t; ap = raw_p;
            t1 = temp_coef[15:0];
            t2 = sext16(temp_coef[31:16]);
            t3 = sext16(temp_coef[47:32]);
            p1 = press_low[15:0];
            p2 = sext16(press_low[31:16]);
            p3 = sext16(press_low[47:32]);
            p4 = sext16(press_low[63:48]);
            p5 = sext16(press_high[15:0]);
            p6 = sext16(press_high[31:16]);
            p7 = sext16(press_high[47:32]);
            p8 = sext16(press_high[63:48]);
            p9 = sext16(press_nine);

            // temperature polynomial, fine temperature in 1/5120 degC
            a = (at >> 3) - (t1 << 1);
            v1 = shr_signed(a * t2, 11);
            b = (at >> 4) - t1;
            v2 = shr_signed(shr_signed(b * b, 12) * t3, 14);
            fine = v1 + v2;
            centi = shr_signed(fine * 64'd5 + 64'd128, 8);
            if (centi < -32768) centi = -32768;
            if (centi > 32767) centi = 32767;
            r.temperature_centi = centi[15:0];

            // pressure polynomial, wrapping 64-bit words
            v1 = fine - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = shr_signed(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = shr_signed(((64'd1 << 47) + v1) * p1, 33);
            r.pressure_q8  = '0;
            r.divide_fault = (v1 == 0);
            if (v1 != 0) begin
                pr = 64'd1048576 - ap;
                pr = div_trunc(((pr << 31) - v2) * 64'd3125, v1);
                a = shr_signed(p9 * shr_signed(pr, 13) * shr_signed(pr, 13), 25);
                b = shr_signed(p8 * pr, 19);
                pr = shr_signed(pr + a + b, 8) + (p7 << 4);
                if (pr[63])
                    r.pressure_q8 = '0;
                else if (pr > 64'd33554431)
                    r.pressure_q8 = bscu_pkg::PRESS_MAX;
                else
                    r.pressure_q8 = pr[24:0];
            end
            return r;
        endfunction

        function void note_input(bit [19:0] raw_t, bit [19:0] raw_p);
            pending_readings.push_back(compensate(raw_t, raw_p));
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected item t=%0d p=%0d f=%0b", $time,
                         got.temperature_centi, got.pressure_q8, got.divide_fault);
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            if (got.temperature_centi !== want.temperature_centi) begin
                $display("%0t: temperature_centi expected %0d actual %0d", $time,
                         want.temperature_centi, got.temperature_centi);
                errors++;
            end
            if (got.pressure_q8 !== want.pressure_q8) begin
                $display("%0t: pressure_q8 expected %0d actual %0d", $time,
                         want.pressure_q8, got.pressure_q8);
                errors++;
            end
            if (got.divide_fault !== want.divide_fault) begin
                $display("%0t: divide_fault expected %0b actual %0b", $time,
                         want.divide_fault, got.divide_fault);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [19:0]                      s_raw_temperature = '0;
    logic [19:0]                      s_raw_pressure = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [15:0]               m_temperature_centi;
    logic [24:0]                      m_pressure_q8;
    logic                             m_divide_fault;
    logic                             cfg_wr_en = 1'b0;
    logic [bscu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bscu_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;

    barometric_sensor_compensation_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_temperature   (s_raw_temperature),
        .s_raw_pressure      (s_raw_pressure),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_q8       (m_pressure_q8),
        .m_divide_fault      (m_divide_fault),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data)
    );

    always #CLK_HALF aclk = ~aclk;

    compensation_scoreboard readings = new();
    longint cycle_count = 0;
    bit     steady_sender = 1'b0;   // no gaps from the sender
    bit     steady_sink   = 1'b0;   // no stalls on m_ready

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_barometric_sensor_compensation_unit: FAIL");
            $finish;
        end
    end

    // result side backpressure, ~15% stall unless a steady stretch is on
    always @(posedge aclk)
        m_ready <= steady_sink ? 1'b1 : ($urandom_range(99) >= 15);

    // handshake monitor: note inputs, check outputs
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            readings.note_input(s_raw_temperature, s_raw_pressure);
        if (aresetn && m_valid && m_ready)
            readings.check_result('{m_temperature_centi, m_pressure_q8, m_divide_fault});
    end

    // ------------------------------------------------------------------
    // Drivers (entered right at a rising edge)
    // ------------------------------------------------------------------
    task automatic write_reg(logic [bscu_pkg::CFG_INDEX_W-1:0] idx, bit [63:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        readings.set_reg(idx, data);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one item; optional gap first, valid held until the handshake
    task automatic send_item(bit [19:0] raw_t, bit [19:0] raw_p);
        while (!steady_sender && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_temperature <= raw_t;
        s_raw_pressure    <= raw_p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender holds off until every expected reading is back
    task automatic drain();
        end_burst();
        while (readings.pending_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_set(int which);
        bit [63:0] tc, pl, ph, p9;
        // typical factory calibration
        tc = {16'(-1000), 16'(26435), 16'(27504)};
        pl = {16'(2855), 16'(3024), 16'(-10685), 16'(36477)};
        ph = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
        p9 = 64'(6000);
        case (which)
            SET_ONES: begin
                tc = '1; pl = '1; ph = '1; p9 = '1;
            end
            SET_EXT_POS: begin
                tc = {16'h7FFF, 16'h7FFF, 16'hFFFF};
                pl = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
                ph = {4{16'h7FFF}};
                p9 = 64'h7FFF;
            end
            SET_EXT_NEG: begin
                tc = {16'h8000, 16'h8000, 16'h0000};
                pl = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
                ph = {4{16'h8000}};
                p9 = 64'hFFFF_FFFF_FFFF_8000;
            end
            SET_NO_P1:  pl[15:0] = 16'h0000;
            SET_RANDOM: begin
                tc = rand64(); pl = rand64(); ph = rand64(); p9 = rand64();
            end
            SET_NEAR_TYP: begin
                tc[15:0]  = tc[15:0] + 16'($urandom_range(2000)) - 16'd1000;
                tc[31:16] = tc[31:16] + 16'($urandom_range(2000)) - 16'd1000;
                pl[15:0]  = pl[15:0] + 16'($urandom_range(4000)) - 16'd2000;
                ph[63:48] = ph[63:48] + 16'($urandom_range(2000)) - 16'd1000;
                p9        = 64'($urandom_range(12000));
            end
            default: ;
        endcase
        write_reg(bscu_pkg::CFG_TEMP_COEF, tc);
        write_reg(bscu_pkg::CFG_PRESS_LOW, pl);
        write_reg(bscu_pkg::CFG_PRESS_HIGH, ph);
        write_reg(bscu_pkg::CFG_PRESS_NINE, p9);
    endtask

    // mostly plausible conversions, some anywhere in the 20-bit range
    task automatic random_items(int count);
        bit [19:0] rt, rp;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) begin
                rt = 20'($urandom_range(600000, 400000));
                rp = 20'($urandom_range(500000, 200000));
            end else begin
                rt = 20'($urandom());
                rp = 20'($urandom());
            end
            send_item(rt, rp);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset calibration is all zero: divisor is zero, fault every item
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        random_items(8);
        drain();

        // typical set with a directed sweep of field extremes
        load_set(SET_TYPICAL);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h00000, 20'hFFFFF);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'hAAAAA, 20'h55555);
        send_item(20'h55555, 20'hAAAAA);
        send_item(20'd519888, 20'd415148);   // room temperature, sea level
        send_item(20'd440000, 20'd300000);
        send_item(20'd600000, 20'd200000);
        send_item(20'd1, 20'd1);
        send_item(20'd1048574, 20'd1048574);
        random_items(300);
        drain();

        // long stretch with no idling on either side
        steady_sender = 1'b1;
        steady_sink   = 1'b1;
        random_items(250);
        end_burst();
        steady_sender = 1'b0;
        steady_sink   = 1'b0;
        drain();

        load_set(SET_NO_P1);        // zero divisor with sane temperature
        random_items(80);
        drain();

        load_set(SET_ONES);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        random_items(80);
        drain();

        load_set(SET_EXT_POS);      // saturation high, wrapped intermediates
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        random_items(80);
        drain();

        load_set(SET_EXT_NEG);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        random_items(80);
        drain();

        for (int k = 0; k < 4; k++) begin
            load_set(SET_RANDOM);
            random_items(50);
            drain();
        end

        for (int k = 0; k < 4; k++) begin
            load_set(SET_NEAR_TYP);
            random_items(150);
            drain();
        end

        if (readings.errors == 0)
            $display("tb_barometric_sensor_compensation_unit: PASS");
        else
            $display("tb_barometric_sensor_compensation_unit: FAIL");
        $finish;
    end

endmodule
